// ----- hdl/sqt_pkg.sv -----
// shared types and constants for the search query tokenizer
`timescale 1ns / 1ps
`default_nettype none

package sqt_pkg;

  // byte offset counter width, offsets saturate at all ones
  localparam int OFFSET_BITS = 16;
  // compare width wide enough for offsets and 16-bit limits
  localparam int CMP_W = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [CMP_W-1:0]       cmp_t;

  localparam offset_t OFFSET_MAX = '1;

  // result queue, depth must be a power of two
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_MAX_QUERY_BYTES = 2'd0,
    REG_MAX_TOKEN_COUNT = 2'd1,
    REG_MAX_TOKEN_BYTES = 2'd2,
    REG_MAX_NESTING     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] max_query_bytes;
    logic [15:0] max_token_count;
    logic [15:0] max_token_bytes;
    logic [15:0] max_nesting;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    max_query_bytes: 16'd4096,
    max_token_count: 16'd1024,
    max_token_bytes: 16'd256,
    max_nesting:     16'd64
  };

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_END  = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    REC_TEXT  = 2'd0,
    REC_TOKEN = 2'd1,
    REC_ERROR = 2'd2
  } rec_kind_t;

  typedef enum logic [3:0] {
    TOK_WORD     = 4'd0,
    TOK_AND      = 4'd1,
    TOK_OR       = 4'd2,
    TOK_NOT      = 4'd3,
    TOK_TO       = 4'd4,
    TOK_LPAREN   = 4'd5,
    TOK_RPAREN   = 4'd6,
    TOK_COLON    = 4'd7,
    TOK_CARET    = 4'd8,
    TOK_LBRACKET = 4'd9,
    TOK_RBRACKET = 4'd10,
    TOK_STAR     = 4'd11,
    TOK_PHRASE   = 4'd12,
    TOK_END      = 4'd13
  } tok_kind_t;

  typedef enum logic [2:0] {
    ERR_ZERO_LIMIT   = 3'd0,
    ERR_QUERY_BYTES  = 3'd1,
    ERR_TOKEN_BYTES  = 3'd2,
    ERR_TOKEN_COUNT  = 3'd3,
    ERR_BAD_ESCAPE   = 3'd4,
    ERR_UNTERMINATED = 3'd5
  } err_code_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_BETWEEN = 3'd1,
    MODE_WORD    = 3'd2,
    MODE_PHRASE  = 3'd3,
    MODE_ESCAPE  = 3'd4,
    MODE_ERROR   = 3'd5
  } mode_t;

  typedef struct packed {
    rec_kind_t   rec_kind;
    tok_kind_t   token_kind;
    logic [15:0] position;
    logic [15:0] text_length;
    logic [7:0]  text_byte;
    err_code_t   error_code;
    logic        last;
  } rec_t;

  // lexer to result queue: up to two records per request
  typedef struct packed {
    logic [1:0] cnt;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

endpackage

`default_nettype wire

// ----- hdl/sqt_cfg_regs.sv -----
// limit registers behind the apb-style configuration port
`timescale 1ns / 1ps
`default_nettype none

module sqt_cfg_regs
  import sqt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_reg_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_QUERY_BYTES: cfg.max_query_bytes <= pwdata[15:0];
        REG_MAX_TOKEN_COUNT: cfg.max_token_count <= pwdata[15:0];
        REG_MAX_TOKEN_BYTES: cfg.max_token_bytes <= pwdata[15:0];
        REG_MAX_NESTING:     cfg.max_nesting     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_QUERY_BYTES: prdata = CFG_DATA_W'(cfg.max_query_bytes);
      REG_MAX_TOKEN_COUNT: prdata = CFG_DATA_W'(cfg.max_token_count);
      REG_MAX_TOKEN_BYTES: prdata = CFG_DATA_W'(cfg.max_token_bytes);
      REG_MAX_NESTING:     prdata = CFG_DATA_W'(cfg.max_nesting);
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/sqt_result_fifo.sv -----
// small result queue, two writes and one read per cycle
`timescale 1ns / 1ps
`default_nettype none

module sqt_result_fifo
  import sqt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  input  logic  pop,
  output rec_t  head,
  output logic  not_empty,
  output logic  room2
);

  rec_t                 mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] wr_ptr_inc;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_PTR_W:0]   count;

  assign wr_ptr_inc = wr_ptr + RES_PTR_W'(1);
  assign head       = mem[rd_ptr];
  assign not_empty  = (count != '0);
  assign room2      = (count <= (RES_PTR_W+1)'(RES_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(push.cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + RES_PTR_W'(1);
      end
      count <= count + (RES_PTR_W+1)'(push.cnt) - (RES_PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.rec0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_inc] <= push.rec1;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sqt_lexer.sv -----
// lexer state and per-request record generation
`timescale 1ns / 1ps
`default_nettype none

module sqt_lexer
  import sqt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  input  logic [15:0] query_length,
  input  cfg_t        cfg,
  output push_t       push
);

  localparam logic [23:0] KW_AND = 24'h414E44;
  localparam logic [23:0] KW_OR  = 24'h004F52;
  localparam logic [23:0] KW_NOT = 24'h4E4F54;
  localparam logic [23:0] KW_TO  = 24'h00544F;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic tok_kind_t single_kind(input logic [7:0] b);
    case (b)
      CH_LPAREN: return TOK_LPAREN;
      CH_RPAREN: return TOK_RPAREN;
      CH_COLON:  return TOK_COLON;
      CH_CARET:  return TOK_CARET;
      CH_LBRACK: return TOK_LBRACKET;
      CH_RBRACK: return TOK_RBRACKET;
      CH_STAR:   return TOK_STAR;
      default:   return TOK_WORD;
    endcase
  endfunction

  function automatic logic [7:0] upper(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) ? (b - 8'h20) : b;
  endfunction

  function automatic logic [15:0] sat_pos(input offset_t o);
    if (cmp_t'(o) > cmp_t'(16'hFFFF)) begin
      return 16'hFFFF;
    end
    return 16'(o);
  endfunction

  function automatic rec_t mk_text(input logic [7:0] b);
    rec_t r;
    r           = '0;
    r.rec_kind  = REC_TEXT;
    r.text_byte = b;
    return r;
  endfunction

  function automatic rec_t mk_token(input tok_kind_t k, input logic [15:0] pos,
                                    input logic [15:0] len);
    rec_t r;
    r             = '0;
    r.rec_kind    = REC_TOKEN;
    r.token_kind  = k;
    r.position    = pos;
    r.text_length = len;
    return r;
  endfunction

  function automatic rec_t mk_error(input err_code_t c, input logic [15:0] pos);
    rec_t r;
    r            = '0;
    r.rec_kind   = REC_ERROR;
    r.position   = pos;
    r.error_code = c;
    return r;
  endfunction

  // state
  mode_t       mode, mode_next;
  offset_t     byte_offset, byte_offset_next;
  offset_t     token_start, token_start_next;
  logic [15:0] token_length, token_length_next;
  logic [15:0] tokens_emitted, tokens_emitted_next;
  logic [23:0] keyword_prefix, keyword_prefix_next;
  offset_t     escape_offset, escape_offset_next;
  logic        too_long, too_long_next;

  // decode
  logic        first_item, limit_zero, first_err, offset_full, word_byte;
  rec_t        first_rec;
  mode_t       mode_eff;
  tok_kind_t   close_tk;
  rec_t        close_rec;
  logic        close_ok;
  logic [15:0] single_cnt;
  rec_t        single_rec;
  logic        single_ok;
  logic        grow_too_long;
  logic [15:0] grow_len;

  rec_t        recs [2];
  logic [1:0]  n_rec;
  logic        do_between;

  assign first_item = (mode == MODE_IDLE);
  assign limit_zero = (cfg.max_query_bytes == 16'd0) || (cfg.max_token_count == 16'd0) ||
                      (cfg.max_token_bytes == 16'd0) || (cfg.max_nesting == 16'd0);
  assign first_err  = first_item && (limit_zero || (query_length > cfg.max_query_bytes));
  assign first_rec  = limit_zero ? mk_error(ERR_ZERO_LIMIT, 16'd0)
                                 : mk_error(ERR_QUERY_BYTES, cfg.max_query_bytes);
  assign mode_eff   = first_item ? (first_err ? MODE_ERROR : MODE_BETWEEN) : mode;

  assign offset_full = (cmp_t'(byte_offset) >= cmp_t'(cfg.max_query_bytes));
  assign word_byte   = !is_space(data_byte) && (single_kind(data_byte) == TOK_WORD) &&
                       (data_byte != CH_QUOTE);

  assign grow_too_long = too_long || (token_length >= cfg.max_token_bytes);
  assign grow_len      = (token_length == 16'hFFFF) ? token_length : token_length + 16'd1;

  // keyword match on a finished word
  always_comb begin
    if (mode == MODE_PHRASE) begin
      close_tk = TOK_PHRASE;
    end else if ((token_length == 16'd3) && (keyword_prefix == KW_AND)) begin
      close_tk = TOK_AND;
    end else if ((token_length == 16'd2) && (keyword_prefix == KW_OR)) begin
      close_tk = TOK_OR;
    end else if ((token_length == 16'd3) && (keyword_prefix == KW_NOT)) begin
      close_tk = TOK_NOT;
    end else if ((token_length == 16'd2) && (keyword_prefix == KW_TO)) begin
      close_tk = TOK_TO;
    end else begin
      close_tk = TOK_WORD;
    end
  end

  // word or phrase close with size and count checks
  always_comb begin
    close_ok = 1'b0;
    if (too_long || (token_length > cfg.max_token_bytes)) begin
      close_rec = mk_error(ERR_TOKEN_BYTES, sat_pos(token_start));
    end else if (tokens_emitted >= cfg.max_token_count) begin
      close_rec = mk_error(ERR_TOKEN_COUNT, sat_pos(token_start));
    end else begin
      close_rec = mk_token(close_tk, sat_pos(token_start), token_length);
      close_ok  = 1'b1;
    end
  end

  // single-character token, counted after a word that closes on the same byte
  assign single_cnt = (mode == MODE_WORD) ? tokens_emitted + 16'd1 : tokens_emitted;

  always_comb begin
    single_ok = 1'b0;
    if (cfg.max_token_bytes == 16'd0) begin
      single_rec = mk_error(ERR_TOKEN_BYTES, sat_pos(byte_offset));
    end else if (single_cnt >= cfg.max_token_count) begin
      single_rec = mk_error(ERR_TOKEN_COUNT, sat_pos(byte_offset));
    end else begin
      single_rec = mk_token(single_kind(data_byte), sat_pos(byte_offset), 16'd1);
      single_ok  = 1'b1;
    end
  end

  always_comb begin
    mode_next           = mode_eff;
    byte_offset_next    = byte_offset;
    token_start_next    = token_start;
    token_length_next   = token_length;
    tokens_emitted_next = tokens_emitted;
    keyword_prefix_next = keyword_prefix;
    escape_offset_next  = escape_offset;
    too_long_next       = too_long;
    recs[0]             = '0;
    recs[1]             = '0;
    n_rec               = 2'd0;
    do_between          = 1'b0;

    if (first_err) begin
      recs[0] = first_rec;
      n_rec   = 2'd1;
    end

    if (req_type == REQ_END) begin
      case (mode_eff)
        MODE_WORD: begin
          recs[n_rec[0]] = close_rec;
          n_rec          = n_rec + 2'd1;
        end
        MODE_PHRASE: begin
          recs[n_rec[0]] = mk_error(ERR_UNTERMINATED, sat_pos(token_start));
          n_rec          = n_rec + 2'd1;
        end
        MODE_ESCAPE: begin
          recs[n_rec[0]] = mk_error(ERR_BAD_ESCAPE, sat_pos(escape_offset));
          n_rec          = n_rec + 2'd1;
        end
        default: ;
      endcase
      recs[n_rec[0]]      = mk_token(TOK_END, sat_pos(byte_offset), 16'd0);
      n_rec               = n_rec + 2'd1;
      mode_next           = MODE_IDLE;
      byte_offset_next    = '0;
      token_start_next    = '0;
      token_length_next   = '0;
      tokens_emitted_next = '0;
      keyword_prefix_next = '0;
      escape_offset_next  = '0;
      too_long_next       = 1'b0;
    end else begin
      if (!first_err) begin
        if (offset_full) begin
          recs[n_rec[0]] = mk_error(ERR_QUERY_BYTES, cfg.max_query_bytes);
          n_rec          = n_rec + 2'd1;
          mode_next      = MODE_ERROR;
        end else begin
          case (mode_eff)
            MODE_WORD: begin
              if (word_byte) begin
                if (token_length < 16'd3) begin
                  keyword_prefix_next = {keyword_prefix[15:0], upper(data_byte)};
                end
                too_long_next     = grow_too_long;
                token_length_next = grow_len;
                recs[n_rec[0]]    = mk_text(data_byte);
                n_rec             = n_rec + 2'd1;
              end else begin
                recs[n_rec[0]] = close_rec;
                n_rec          = n_rec + 2'd1;
                if (close_ok) begin
                  tokens_emitted_next = tokens_emitted + 16'd1;
                  mode_next           = MODE_BETWEEN;
                  do_between          = 1'b1;
                end else begin
                  mode_next = MODE_ERROR;
                end
              end
            end
            MODE_PHRASE: begin
              if (data_byte == CH_QUOTE) begin
                recs[n_rec[0]] = close_rec;
                n_rec          = n_rec + 2'd1;
                if (close_ok) begin
                  tokens_emitted_next = tokens_emitted + 16'd1;
                  mode_next           = MODE_BETWEEN;
                end else begin
                  mode_next = MODE_ERROR;
                end
              end else if (data_byte == CH_BSLASH) begin
                escape_offset_next = byte_offset;
                mode_next          = MODE_ESCAPE;
              end else begin
                too_long_next     = grow_too_long;
                token_length_next = grow_len;
                recs[n_rec[0]]    = mk_text(data_byte);
                n_rec             = n_rec + 2'd1;
              end
            end
            MODE_ESCAPE: begin
              if ((data_byte == CH_QUOTE) || (data_byte == CH_BSLASH)) begin
                too_long_next     = grow_too_long;
                token_length_next = grow_len;
                recs[n_rec[0]]    = mk_text(data_byte);
                n_rec             = n_rec + 2'd1;
                mode_next         = MODE_PHRASE;
              end else begin
                recs[n_rec[0]] = mk_error(ERR_BAD_ESCAPE, sat_pos(escape_offset));
                n_rec          = n_rec + 2'd1;
                mode_next      = MODE_ERROR;
              end
            end
            MODE_ERROR: ;
            default: do_between = 1'b1;
          endcase

          if (do_between && !is_space(data_byte)) begin
            if (single_kind(data_byte) != TOK_WORD) begin
              recs[n_rec[0]] = single_rec;
              n_rec          = n_rec + 2'd1;
              if (single_ok) begin
                tokens_emitted_next = single_cnt + 16'd1;
                mode_next           = MODE_BETWEEN;
              end else begin
                mode_next = MODE_ERROR;
              end
            end else if (data_byte == CH_QUOTE) begin
              token_start_next    = byte_offset;
              token_length_next   = 16'd0;
              too_long_next       = 1'b0;
              keyword_prefix_next = '0;
              mode_next           = MODE_PHRASE;
            end else begin
              token_start_next    = byte_offset;
              token_length_next   = 16'd1;
              too_long_next       = (cfg.max_token_bytes == 16'd0);
              keyword_prefix_next = {16'd0, upper(data_byte)};
              recs[n_rec[0]]      = mk_text(data_byte);
              n_rec               = n_rec + 2'd1;
              mode_next           = MODE_WORD;
            end
          end
        end
      end
      if (byte_offset != OFFSET_MAX) begin
        byte_offset_next = byte_offset + OFFSET_BITS'(1);
      end
    end

    if (n_rec != 2'd0) begin
      recs[n_rec[1]].last = 1'b1;
    end
  end

  assign push.cnt  = fire ? n_rec : 2'd0;
  assign push.rec0 = recs[0];
  assign push.rec1 = recs[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      byte_offset    <= '0;
      token_start    <= '0;
      token_length   <= '0;
      tokens_emitted <= '0;
      keyword_prefix <= '0;
      escape_offset  <= '0;
      too_long       <= 1'b0;
    end else if (fire) begin
      mode           <= mode_next;
      byte_offset    <= byte_offset_next;
      token_start    <= token_start_next;
      token_length   <= token_length_next;
      tokens_emitted <= tokens_emitted_next;
      keyword_prefix <= keyword_prefix_next;
      escape_offset  <= escape_offset_next;
      too_long       <= too_long_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/search_query_tokenizer_core.sv -----
// top level of the boolean search query tokenizer
// path: a request waits in the input register, then its results go into the four-entry result
//   queue, whose head drives the ports; throughput: one request per cycle while the queue has
//   room for two results; results leave one at a time through the queue's single read port
// reset: rst is synchronous, active high; it clears the input stage, the lexer state and the
//   result queue, and returns the limit registers to their defaults; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module search_query_tokenizer_core
  import sqt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  req_type,
  input  logic [7:0]            data_byte,
  input  logic [15:0]           query_length,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            rec_kind,
  output logic [3:0]            token_kind,
  output logic [15:0]           position,
  output logic [15:0]           text_length,
  output logic [7:0]            text_byte,
  output logic [2:0]            error_code,
  output logic                  last
);

  cfg_t  cfg;
  push_t push;
  rec_t  head;
  logic  room2;
  logic  advance;
  logic  pop;

  // input register: one request waits here until the queue has room for two results
  logic        item_valid;
  logic        item_req_type;
  logic [7:0]  item_byte;
  logic [15:0] item_qlen;

  // stall depends only on registered state, never on in_valid
  assign in_stall = item_valid && !room2;
  assign advance  = item_valid && room2;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  // payload only loads on an accepted request
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_req_type <= req_type;
      item_byte     <= data_byte;
      item_qlen     <= query_length;
    end
  end

  sqt_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // lexer: all per-request work between the input register and the queue
  sqt_lexer u_lexer (
    .clk          (clk),
    .rst          (rst),
    .fire         (advance),
    .req_type     (item_req_type),
    .data_byte    (item_byte),
    .query_length (item_qlen),
    .cfg          (cfg),
    .push         (push)
  );

  // result queue head drives the output ports directly and holds while stalled
  sqt_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (out_valid),
    .room2     (room2)
  );

  assign rec_kind    = head.rec_kind;
  assign token_kind  = head.token_kind;
  assign position    = head.position;
  assign text_length = head.text_length;
  assign text_byte   = head.text_byte;
  assign error_code  = head.error_code;
  assign last        = head.last;

endmodule

`default_nettype wire

// ----- hdl/sqt_checker.sv -----
// port-level checks for the tokenizer top, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module sqt_checker
  import sqt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  rec_kind,
  input logic [3:0]  token_kind,
  input logic [15:0] position,
  input logic [15:0] text_length,
  input logic [7:0]  text_byte,
  input logic [2:0]  error_code,
  input logic        last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rec_kind) && $stable(token_kind) &&
      $stable(position) && $stable(text_length) && $stable(text_byte) &&
      $stable(error_code) && $stable(last))
    else $error("stalled result changed");

  // input backpressure only comes from a result queue without room for two results
  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // the end token closes its request and carries no text
  a_end_token: assert property (@(posedge clk) disable iff (rst)
    out_valid && (rec_kind == REC_TOKEN) && (token_kind == TOK_END) |->
      last && (text_length == 16'd0))
    else $error("end token malformed");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid && !in_stall)
    else $error("activity right after reset");

endmodule

bind search_query_tokenizer_core sqt_checker u_sqt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .rec_kind    (rec_kind),
  .token_kind  (token_kind),
  .position    (position),
  .text_length (text_length),
  .text_byte   (text_byte),
  .error_code  (error_code),
  .last        (last)
);

`default_nettype wire

// ----- test/tb.sv -----
// self-checking testbench for the search query tokenizer core
`timescale 1ns / 1ps

module tb;
  import sqt_pkg::*;

  // watchdog: cycles with no request, result or register traffic
  localparam int QUIET_LIMIT = 1000;
  // idle cycles after the last result before a register write or the end
  localparam int SETTLE_CYCLES = 8;
  // mismatch lines printed at most
  localparam int MSG_CAP = 40;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  // keyword prefixes as upper-case ascii, right aligned
  localparam logic [23:0] KW_AND = "AND";
  localparam logic [23:0] KW_OR = "OR";
  localparam logic [23:0] KW_NOT = "NOT";
  localparam logic [23:0] KW_TO = "TO";

  typedef struct packed {
    req_type_t   kind;
    logic [7:0]  b;
    logic [15:0] qlen;
  } query_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = 1'b0;
  logic [7:0]  data_byte = '0;
  logic [15:0] query_length = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  rec_kind;
  logic [3:0]  token_kind;
  logic [15:0] position;
  logic [15:0] text_length;
  logic [7:0]  text_byte;
  logic [2:0]  error_code;
  logic        last;

  search_query_tokenizer_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .data_byte(data_byte), .query_length(query_length),
    .out_valid(out_valid), .out_stall(out_stall), .rec_kind(rec_kind),
    .token_kind(token_kind), .position(position), .text_length(text_length),
    .text_byte(text_byte), .error_code(error_code), .last(last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // lexer prediction: own copy of the limits and the lexer state
  // ---------------------------------------------------------------------------
  cfg_t        lim = CFG_RESET;
  mode_t       lmode = MODE_IDLE;
  offset_t     boff = '0;        // byte offset within the query, saturating
  logic [15:0] tstart = '0;      // start offset of the open token
  logic [15:0] tlen = '0;        // unescaped length of the open token
  logic [15:0] ntok = '0;        // tokens emitted in this query
  logic [15:0] esc_off = '0;     // offset of the pending backslash
  logic [23:0] kw = '0;          // first three bytes of a word, upper case
  logic        started = 1'b0;   // first request of the query already seen
  logic        overlong = 1'b0;  // open token grew past max_token_bytes
  int          step_cnt;         // records made by the current request

  rec_t lexed_recs[$];           // records still owed by the block

  function automatic void push_rec(rec_t r);
    lexed_recs.insert(lexed_recs.size(), r);
    step_cnt++;
  endfunction

  function automatic void raise_err(err_code_t code, logic [15:0] pos);
    rec_t r;
    r = '0;
    r.rec_kind = REC_ERROR;
    r.position = pos;
    r.error_code = code;
    push_rec(r);
    lmode = MODE_ERROR;
  endfunction

  function automatic void emit_token(tok_kind_t tk, logic [15:0] pos, logic [15:0] len);
    rec_t r;
    r = '0;
    r.rec_kind = REC_TOKEN;
    r.token_kind = tk;
    r.position = pos;
    r.text_length = len;
    push_rec(r);
  endfunction

  function automatic void emit_text(logic [7:0] b);
    rec_t r;
    r = '0;
    r.rec_kind = REC_TEXT;
    r.text_byte = b;
    push_rec(r);
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
  endfunction

  // single-character tokens, word meaning none
  function automatic tok_kind_t char_token(logic [7:0] b);
    case (b)
      "(": return TOK_LPAREN;
      ")": return TOK_RPAREN;
      ":": return TOK_COLON;
      "^": return TOK_CARET;
      "[": return TOK_LBRACKET;
      "]": return TOK_RBRACKET;
      "*": return TOK_STAR;
      default: return TOK_WORD;
    endcase
  endfunction

  function automatic logic [7:0] upcase(logic [7:0] b);
    return (b >= "a" && b <= "z") ? b - 8'd32 : b;
  endfunction

  // size check first, then count check
  function automatic bit add_token(tok_kind_t tk, logic [15:0] pos, logic [15:0] len, bit over);
    if (over || len > lim.max_token_bytes) begin
      raise_err(ERR_TOKEN_BYTES, pos);
      return 1'b0;
    end
    if (ntok >= lim.max_token_count) begin
      raise_err(ERR_TOKEN_COUNT, pos);
      return 1'b0;
    end
    emit_token(tk, pos, len);
    ntok++;
    return 1'b1;
  endfunction

  function automatic void grow_token();
    if (tlen >= lim.max_token_bytes) overlong = 1'b1;
    if (tlen != 16'hFFFF) tlen++;
  endfunction

  function automatic bit close_word();
    tok_kind_t tk;
    tk = TOK_WORD;
    if (tlen == 16'd3 && kw == KW_AND) tk = TOK_AND;
    else if (tlen == 16'd2 && kw == KW_OR) tk = TOK_OR;
    else if (tlen == 16'd3 && kw == KW_NOT) tk = TOK_NOT;
    else if (tlen == 16'd2 && kw == KW_TO) tk = TOK_TO;
    lmode = MODE_BETWEEN;
    return add_token(tk, tstart, tlen, overlong);
  endfunction

  function automatic void open_text();
    tstart = boff;
    tlen = '0;
    overlong = 1'b0;
    kw = '0;
  endfunction

  function automatic void between_byte(logic [7:0] b);
    tok_kind_t sk;
    bit ok;
    sk = char_token(b);
    if (is_blank(b)) begin
      // blanks only separate
    end else if (sk != TOK_WORD) begin
      ok = add_token(sk, boff, 16'd1, 1'b0);
    end else if (b == CH_QUOTE) begin
      open_text();
      lmode = MODE_PHRASE;
    end else begin
      open_text();
      grow_token();
      kw = {16'd0, upcase(b)};
      emit_text(b);
      lmode = MODE_WORD;
    end
  endfunction

  // one accepted request: appends its records to lexed_recs
  function automatic void lex_request(req_type_t req, logic [7:0] b, logic [15:0] qlen);
    bit ok;
    step_cnt = 0;
    // limit checks on the first request of a query
    if (!started) begin
      started = 1'b1;
      lmode = MODE_BETWEEN;
      if (lim.max_query_bytes == 0 || lim.max_token_count == 0 ||
          lim.max_token_bytes == 0 || lim.max_nesting == 0)
        raise_err(ERR_ZERO_LIMIT, '0);
      else if (qlen > lim.max_query_bytes)
        raise_err(ERR_QUERY_BYTES, lim.max_query_bytes);
    end
    if (req == REQ_END) begin
      // close what is open, then the end token with no limit check
      case (lmode)
        MODE_WORD:   ok = close_word();
        MODE_PHRASE: raise_err(ERR_UNTERMINATED, tstart);
        MODE_ESCAPE: raise_err(ERR_BAD_ESCAPE, esc_off);
        default: ;
      endcase
      // offsets and positions are both 16 bits, so no saturation step here
      emit_token(TOK_END, boff, '0);
      lmode = MODE_IDLE;
      started = 1'b0;
      boff = '0;
      tstart = '0;
      tlen = '0;
      ntok = '0;
      kw = '0;
      esc_off = '0;
      overlong = 1'b0;
    end else begin
      // silent after an error, except that overrunning bytes keep reporting
      if (lmode != MODE_ERROR || step_cnt == 0) begin
        if (boff >= lim.max_query_bytes) raise_err(ERR_QUERY_BYTES, lim.max_query_bytes);
        else case (lmode)
          MODE_WORD: begin
            if (!is_blank(b) && char_token(b) == TOK_WORD && b != CH_QUOTE) begin
              if (tlen < 16'd3) kw = {kw[15:0], upcase(b)};
              grow_token();
              emit_text(b);
            end else if (close_word()) begin
              between_byte(b);
            end
          end
          MODE_PHRASE: begin
            if (b == CH_QUOTE) begin
              lmode = MODE_BETWEEN;
              ok = add_token(TOK_PHRASE, tstart, tlen, overlong);
            end else if (b == CH_BSLASH) begin
              esc_off = boff;
              lmode = MODE_ESCAPE;
            end else begin
              grow_token();
              emit_text(b);
            end
          end
          MODE_ESCAPE: begin
            if (b == CH_QUOTE || b == CH_BSLASH) begin
              grow_token();
              emit_text(b);
              lmode = MODE_PHRASE;
            end else begin
              raise_err(ERR_BAD_ESCAPE, esc_off);
            end
          end
          MODE_ERROR: ;
          default: between_byte(b);
        endcase
      end
      if (boff != OFFSET_MAX) boff++;
    end
    // mark the final record of this request
    if (step_cnt > 0) lexed_recs[lexed_recs.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length, random gaps
  // ---------------------------------------------------------------------------
  query_req_t query_reqs[$];  // requests waiting to be sent
  int  burst_left = 0;
  int  gap_left = 0;
  bit  gaps_on = 1'b0;
  int  n_reqs_taken = 0;

  always @(posedge clk) begin : driver
    query_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // request taken at this edge: predict its records
      if (in_valid && !in_stall) begin
        lex_request(req_type_t'(req_type), data_byte, query_length);
        n_reqs_taken++;
      end
      // payload only changes once the slot is free
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (query_reqs.size() > 0) begin
          nxt = query_reqs.pop_front();
          in_valid <= 1'b1;
          req_type <= nxt.kind;
          data_byte <= nxt.b;
          query_length <= nxt.qlen;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = gaps_on ? $urandom_range(1, 8) : 0;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and receiver stall pattern
  // ---------------------------------------------------------------------------
  int stall_mode = 0;  // 0 never, 1 light random, 2 periodic stretches, 3 heavy random
  int stall_tick = 0;
  int n_recs_checked = 0;
  int n_errors = 0;
  int n_msgs = 0;

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] seen);
    if (seen !== want) begin
      n_errors++;
      if (n_msgs < MSG_CAP) begin
        n_msgs++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      end
    end
  endfunction

  always @(posedge clk) begin : monitor
    rec_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (lexed_recs.size() == 0) begin
          n_errors++;
          if (n_msgs < MSG_CAP) begin
            n_msgs++;
            $display("%0t: result with none expected, expected nothing, actual kind %0h",
                     $time, rec_kind);
          end
        end else begin
          want = lexed_recs.pop_front();
          n_recs_checked++;
          check_field("rec_kind", 16'(want.rec_kind), 16'(rec_kind));
          check_field("token_kind", 16'(want.token_kind), 16'(token_kind));
          check_field("position", want.position, position);
          check_field("text_length", want.text_length, text_length);
          check_field("text_byte", 16'(want.text_byte), 16'(text_byte));
          check_field("error_code", 16'(want.error_code), 16'(error_code));
          check_field("last", 16'(want.last), 16'(last));
        end
      end
      stall_tick++;
      case (stall_mode)
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ((stall_tick % 11) < 5);
        3: out_stall <= $urandom_range(0, 1);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // watchdog on handshake activity
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  logic [7:0] qbuf[$];  // bytes of the query being built
  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-./";
  string single_chars = "()[]:^*";
  int n_settings = 0;

  function automatic void put_byte(logic [7:0] b);
    qbuf.insert(qbuf.size(), b);
  endfunction

  task automatic push_item(req_type_t kind, logic [7:0] b, logic [15:0] qlen);
    query_req_t r;
    r.kind = kind;
    r.b = b;
    r.qlen = qlen;
    query_reqs.insert(query_reqs.size(), r);
  endtask

  // qbuf plus end request; declared length goes on the first request only
  task automatic flush_query(logic [15:0] qlen);
    for (int i = 0; i < qbuf.size(); i++)
      push_item(REQ_BYTE, qbuf[i], (i == 0) ? qlen : 16'($urandom));
    push_item(REQ_END, 8'($urandom), (qbuf.size() == 0) ? qlen : 16'($urandom));
    qbuf.delete();
  endtask

  task automatic queue_text(string s, logic [15:0] qlen);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    flush_query(qlen);
  endtask

  function automatic logic [7:0] word_char();
    return word_chars[$urandom_range(0, word_chars.len() - 1)];
  endfunction

  // mostly well-formed query with random content, some noise and broken phrases
  task automatic queue_random_query();
    int nseg;
    int len;
    string kwd;
    logic [15:0] qlen;
    nseg = $urandom_range(0, 7);
    for (int s = 0; s < nseg; s++) begin
      case ($urandom_range(0, 11))
        0, 1: begin
          // keyword in mixed case
          case ($urandom_range(0, 3))
            0: kwd = "and";
            1: kwd = "or";
            2: kwd = "not";
            default: kwd = "to";
          endcase
          for (int i = 0; i < kwd.len(); i++)
            put_byte($urandom_range(0, 1) ? kwd[i] - 8'd32 : kwd[i]);
        end
        2, 3: begin
          len = $urandom_range(1, 7);
          for (int i = 0; i < len; i++) put_byte(word_char());
        end
        4, 5: put_byte($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13)));
        6: put_byte(single_chars[$urandom_range(0, single_chars.len() - 1)]);
        7, 8: begin
          // phrase with escapes
          put_byte(CH_QUOTE);
          len = $urandom_range(0, 5);
          for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 5))
              0: begin put_byte(CH_BSLASH); put_byte(CH_QUOTE); end
              1: begin put_byte(CH_BSLASH); put_byte(CH_BSLASH); end
              2: put_byte(CH_SPACE);
              default: put_byte(word_char());
            endcase
          end
          put_byte(CH_QUOTE);
        end
        9: put_byte(8'($urandom));
        10: begin
          // broken phrase: bad escape or left open
          put_byte(CH_QUOTE);
          put_byte(word_char());
          if ($urandom_range(0, 1)) begin
            put_byte(CH_BSLASH);
            put_byte(word_char());
          end
        end
        default: put_byte(CH_SPACE);
      endcase
    end
    case ($urandom_range(0, 9))
      0: qlen = 16'($urandom);
      1: qlen = lim.max_query_bytes;
      2: qlen = lim.max_query_bytes + 16'd1;
      default: qlen = 16'(qbuf.size());
    endcase
    flush_query(qlen);
  endtask

  task automatic fill_random(int n);
    int stop_at;
    stop_at = query_reqs.size() + n;
    while (query_reqs.size() < stop_at) queue_random_query();
  endtask

  // wait until nothing is in flight, then let the block go quiet
  task automatic settle();
    while (query_reqs.size() != 0 || in_valid || lexed_recs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // apb write: setup cycle, access cycle, register written at the pready edge
  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * idx);
    pwdata <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAX_QUERY_BYTES: lim.max_query_bytes = val;
      REG_MAX_TOKEN_COUNT: lim.max_token_count = val;
      REG_MAX_TOKEN_BYTES: lim.max_token_bytes = val;
      default:             lim.max_nesting = val;
    endcase
  endtask

  task automatic set_limits(logic [15:0] qb, logic [15:0] tc, logic [15:0] tb_, logic [15:0] ne);
    write_reg(REG_MAX_QUERY_BYTES, qb);
    write_reg(REG_MAX_TOKEN_COUNT, tc);
    write_reg(REG_MAX_TOKEN_BYTES, tb_);
    write_reg(REG_MAX_NESTING, ne);
    @(negedge clk);
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset limits, directed queries, no idling
    gaps_on = 1'b0;
    stall_mode = 0;
    // keywords in mixed case, colon and caret, phrase with both escapes
    queue_text("AnD:oR^\"\\\"\\\\\"", 16'd13);
    // remaining single-character tokens, then a phrase left open at the end
    queue_text("not(TO)*[]\"", 16'd11);
    // bad escape inside a phrase
    queue_text("\"\\q", 16'd3);
    // end of query right after a backslash
    queue_text("\"\\", 16'd2);
    // extreme byte values as one word
    put_byte(8'h00);
    put_byte(8'hFF);
    flush_query(16'd0);
    // declared length over the limit
    queue_text("x", 16'hFFFF);
    settle();

    gaps_on = 1'b1;
    stall_mode = 1;
    fill_random(100);
    settle();

    // tight limits: token size, token count and query length errors
    set_limits(16'd40, 16'd6, 16'd4, 16'd1);
    gaps_on = 1'b1;
    stall_mode = 2;
    queue_text("abcdefg", 16'd7);
    queue_text("a b c d e f g", 16'd13);
    queue_text("x", 16'd41);
    // more bytes than declared, overrun keeps reporting
    for (int i = 0; i < 45; i++) put_byte(CH_SPACE);
    flush_query(16'd3);
    fill_random(60);
    settle();

    // each limit at zero in turn
    stall_mode = 3;
    for (int i = 0; i < 4; i++) begin
      set_limits((i == 0) ? 16'd0 : 16'd50, (i == 1) ? 16'd0 : 16'd50,
                 (i == 2) ? 16'd0 : 16'd50, (i == 3) ? 16'd0 : 16'd50);
      queue_text("ab", 16'd2);
      queue_text("", 16'd0);
      settle();
    end

    // all limits at their maximum, a stretch with no idling
    set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    gaps_on = 1'b0;
    stall_mode = 0;
    fill_random(80);
    settle();

    // all limits at one
    set_limits(16'd1, 16'd1, 16'd1, 16'd1);
    gaps_on = 1'b1;
    stall_mode = 3;
    fill_random(50);
    settle();

    // random moderate limits
    for (int k = 0; k < 2; k++) begin
      set_limits(16'($urandom_range(2, 60)), 16'($urandom_range(1, 12)),
                 16'($urandom_range(1, 8)), 16'($urandom_range(1, 65535)));
      gaps_on = 1'b1;
      stall_mode = 1 + k;
      fill_random(40);
      settle();
    end

    if (lexed_recs.size() != 0) n_errors++;
    $display("tb: %0d requests, %0d results checked over %0d limit settings, %0d errors",
             n_reqs_taken, n_recs_checked, n_settings + 1, n_errors);
    $display("tb: covered keywords, single-character tokens, phrases, escapes and limit errors");
    if (n_errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
